// File: hw/rtl/u8d_pkg.sv
package u8d_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int REP_W    = 3;
    localparam int JOB_DEPTH = 2;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [5:0] CONT_MASK = 6'h3F;
    localparam logic [4:0] LEAD2_MASK = 5'h1F;
    localparam logic [3:0] LEAD3_MASK = 4'h0F;
    localparam logic [2:0] LEAD4_MASK = 3'h7;

    // One decoded word's worth of work: rep replacement results first,
    // then the code point if has_cp is set.
    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             has_cp;
        logic [CP_W-1:0]  cp;
    } t_job;

endpackage

// File: hw/rtl/u8d_front.sv
module u8d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_end_of_text,
    output logic                          o_job_valid,
    output u8d_pkg::t_job                 o_job
);
    import u8d_pkg::*;

    logic [CP_W-1:0]  r_partial, n_partial;
    logic [1:0]       r_expected, n_expected;
    logic [1:0]       r_held, n_held;
    logic             fresh;
    t_job             job;

    always_comb begin
        n_partial  = r_partial;
        n_expected = r_expected;
        n_held     = r_held;
        fresh      = 1'b1;
        job.rep    = '0;
        job.has_cp = 1'b0;
        job.cp     = '0;

        // continue or break an open sequence
        if (r_expected != 2'd0) begin
            if (i_text_byte[7:6] == 2'b10) begin
                fresh      = 1'b0;
                n_partial  = {r_partial[CP_W-7:0], i_text_byte[5:0] & CONT_MASK};
                n_held     = r_held + 2'd1;
                n_expected = r_expected - 2'd1;
                if (n_expected == 2'd0) begin
                    job.has_cp = 1'b1;
                    job.cp     = n_partial;
                    n_partial  = '0;
                    n_held     = '0;
                end
            end else begin
                job.rep    = REP_W'(r_held);
                n_partial  = '0;
                n_expected = '0;
                n_held     = '0;
            end
        end

        if (fresh) begin
            case (i_text_byte) inside
                8'b0???_????: begin
                    job.has_cp = 1'b1;
                    job.cp     = CP_W'(i_text_byte);
                end
                8'b110?_????: begin
                    n_partial  = CP_W'(i_text_byte[4:0] & LEAD2_MASK);
                    n_expected = 2'd1;
                    n_held     = 2'd1;
                end
                8'b1110_????: begin
                    n_partial  = CP_W'(i_text_byte[3:0] & LEAD3_MASK);
                    n_expected = 2'd2;
                    n_held     = 2'd1;
                end
                8'b1111_0???: begin
                    n_partial  = CP_W'(i_text_byte[2:0] & LEAD4_MASK);
                    n_expected = 2'd3;
                    n_held     = 2'd1;
                end
                default: begin
                    job.rep = job.rep + REP_W'(1);
                end
            endcase
        end

        // flush a sequence left open at end of text
        if (i_end_of_text && n_expected != 2'd0) begin
            job.rep    = job.rep + REP_W'(n_held);
            n_partial  = '0;
            n_expected = '0;
            n_held     = '0;
        end
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (job.rep != '0 || job.has_cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_expected <= '0;
            r_held     <= '0;
        end else if (i_accept) begin
            r_partial  <= n_partial;
            r_expected <= n_expected;
            r_held     <= n_held;
        end
    end

endmodule

// File: hw/rtl/u8d_fifo.sv
module u8d_fifo #(
    parameter int DEPTH = u8d_pkg::JOB_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  u8d_pkg::t_job i_wr_job,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output u8d_pkg::t_job o_rd_job
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && o_valid;
    assign o_rd_job = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= advance(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= advance(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/u8d_back.sv
module u8d_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  u8d_pkg::t_job          i_job,
    output logic                   o_take,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [20:0]            o_code_point,
    output logic                   o_last_of_run
);
    import u8d_pkg::*;

    logic              r_busy;
    logic [REP_W-1:0]  r_rep;
    logic              r_has_cp;
    logic [CP_W-1:0]   r_cp;
    logic              last, deliver, finish;

    // replacements go out first, then the code point
    assign last          = (r_rep == '0) || (r_rep == REP_W'(1) && !r_has_cp);
    assign o_empty       = !r_busy;
    assign o_code_point  = (r_rep != '0) ? REPLACEMENT_CP : r_cp;
    assign o_last_of_run = last;

    assign deliver = i_pop && r_busy;
    assign finish  = deliver && last;
    assign o_take  = i_job_valid && (!r_busy || finish);

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_has_cp <= i_job.has_cp;
            r_cp     <= i_job.cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rep  <= '0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_rep  <= i_job.rep;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (deliver && r_rep != '0) begin
            r_rep <= r_rep - REP_W'(1);
        end
    end

endmodule

// File: hw/rtl/utf8_stream_decoder.sv
// Path: a byte that completes a result is written into the job queue, then loaded into the
// emitter's registers, and only then shows on the output.
// Throughput: one byte per cycle while the job queue has room, one result per cycle while
// popped; a byte causing several replacement results holds the emitter until popped,
// and the two-entry queue keeps input open for two more result bytes before full rises.
// Reset: synchronous, active low; clears decode state, job queue and emitter (o_empty high).
module utf8_stream_decoder #(
    parameter int JOB_DEPTH = u8d_pkg::JOB_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input side
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // result side
    output logic        o_empty,
    input  logic        i_pop,
    output logic [20:0] o_code_point,
    output logic        o_last_of_run
);
    import u8d_pkg::*;

    logic  accept;
    logic  job_push;
    t_job  job_in;
    logic  job_valid;
    t_job  job_out;
    logic  job_take;

    // A byte is a word on the input side; take it whenever the job queue has room.
    assign accept = i_push && !o_full;

    // Decoder: track the open sequence and turn each byte into a job that
    // lists its replacement results and its code point, if any.
    u8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_job_valid   (job_push),
        .o_job         (job_in)
    );

    // Short job queue: decouple byte intake from result delivery.
    u8d_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_push),
        .i_wr_job (job_in),
        .o_full   (o_full),
        .i_rd     (job_take),
        .o_valid  (job_valid),
        .o_rd_job (job_out)
    );

    // Emitter: hold one job and drain its results one word per pop.
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job_out),
        .o_take        (job_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_code_point  (o_code_point),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: hw/rtl/u8d_checker.sv
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [20:0] o_code_point,
    input logic        o_last_of_run
);
    import u8d_pkg::*;

    // the output side comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result side not empty after reset");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_code_point)
                                  && $stable(o_last_of_run)))
        else $error("waiting result changed before pop");

    // only replacements precede the last result of a byte
    a_not_last_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_last_of_run) |-> (o_code_point == REPLACEMENT_CP))
        else $error("non-final result is not a replacement");

    // a backed-up queue means the emitter holds work
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("input full while result side empty");

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_code_point  (o_code_point),
    .o_last_of_run (o_last_of_run)
);
